>>> hdl/mfde_pkg.sv
package mfde_pkg;

	// Screen geometry and store size.
	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
	localparam int ADDR_W        = $clog2(STORE_BYTES);

	// Command queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Command codes as they arrive on the kind port.
	localparam logic [2:0] KIND_CLEAR  = 3'd0;
	localparam logic [2:0] KIND_PIXEL  = 3'd1;
	localparam logic [2:0] KIND_LINE   = 3'd2;
	localparam logic [2:0] KIND_CIRCLE = 3'd3;
	localparam logic [2:0] KIND_INVERT = 3'd4;
	localparam logic [2:0] KIND_READ   = 3'd5;

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_PIXEL,
		OP_LINE,
		OP_CIRCLE,
		OP_INVERT,
		OP_READ
	} op_e_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_GEN,
		ST_WR,
		ST_RDOUT
	} state_e_t;

	typedef struct packed {
		op_e_t              op;
		logic [7:0]         first_x;
		logic [7:0]         first_y;
		logic [7:0]         second_x;
		logic [7:0]         second_y;
		logic signed [7:0]  radius;
		logic               pixel_value;
		logic [9:0]         byte_address;
	} cmd_t;

	// Head of the command queue as the back end sees it.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	// Store address of a column within a page.
	function automatic logic [ADDR_W-1:0] pix_addr(input logic [7:0] col, input logic [7:0] page);
		logic [17:0] t;
		begin
			t = 18'(page) * 18'(SCREEN_WIDTH) + 18'(col);
			return t[ADDR_W-1:0];
		end
	endfunction

endpackage

>>> hdl/mfde_front.sv
module mfde_front import mfde_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        kind,
	input  logic [7:0]        first_x,
	input  logic [7:0]        first_y,
	input  logic [7:0]        second_x,
	input  logic [7:0]        second_y,
	input  logic signed [7:0] radius,
	input  logic              pixel_value,
	input  logic [9:0]        byte_address,
	input  logic              init_busy,
	input  logic              pop,
	output q_head_t           head
);

	cmd_t               fifo_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;
	logic               full;
	logic               keep;
	logic               push;
	op_e_t              op;

	// Classify the incoming item; unused codes are dropped here.
	always_comb begin
		keep = 1'b1;
		op   = OP_CLEAR;
		unique case (kind)
			KIND_CLEAR:  op = OP_CLEAR;
			KIND_PIXEL:  op = OP_PIXEL;
			KIND_LINE:   op = OP_LINE;
			KIND_CIRCLE: op = OP_CIRCLE;
			KIND_INVERT: op = OP_INVERT;
			KIND_READ:   op = OP_READ;
			default:     keep = 1'b0;
		endcase
	end

	assign full = (count_q == (QPTR_W+1)'(QDEPTH));
	assign busy = full || init_busy;
	assign push = start && !busy && keep;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{op: op, first_x: first_x, first_y: first_y,
				second_x: second_x, second_y: second_y, radius: radius,
				pixel_value: pixel_value, byte_address: byte_address};
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	assign head.valid = (count_q != '0);
	assign head.cmd   = fifo_q[rd_ptr_q];

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QDEPTH)) else $error("queue overfilled");
	a_busy_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> busy) else $error("item taken during the clearing pass");

endmodule

>>> hdl/mfde_back.sv
module mfde_back import mfde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_head_t    head,
	output logic       pop,
	output logic       init_busy,
	output logic       read_valid,
	output logic [7:0] read_data
);

	state_e_t           state_q, state_d;
	op_e_t              op_q;
	logic               pv_q;
	logic [ADDR_W-1:0]  clr_cnt_q;
	logic [7:0]         mem_q [STORE_BYTES];
	logic [7:0]         rdata_q;
	logic               mem_re, mem_we;
	logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
	logic [7:0]         mem_wdata;
	logic [ADDR_W-1:0]  waddr_q;
	logic [2:0]         wbit_q;
	logic               rd_oob_q;
	logic               read_valid_q;
	logic [7:0]         read_data_q;

	// Line stepper state: major/minor coordinates after the steep swap.
	logic [7:0]         lx_q, ly_q;
	logic               steep_q, mj_neg_q, mn_neg_q;
	logic [8:0]         dmaj_q, dmin_q;
	logic signed [11:0] e_q;
	logic [7:0]         cnt_q;

	// Circle stepper state.
	logic [7:0]         cx_q, cy_q;
	logic signed [8:0]  ca_q, cb_q;
	logic signed [11:0] cerr_q;
	logic [2:0]         oct_q;

	// Invert region walker.
	logic [7:0]         x1_q, x2_q, y2_q;
	logic [8:0]         row_q, col_q;

	logic [7:0]         tx, ty;
	logic               adv, last, capture, next_row;
	logic               row_ok, col_ok, pix_vis;
	logic [7:0]         bmask;

	// Line setup terms from the queue head.
	logic [7:0]         dxa, dya;
	logic               steep0;
	logic [7:0]         dmaj0, dmin0;

	assign dxa    = (head.cmd.second_x > head.cmd.first_x) ?
		head.cmd.second_x - head.cmd.first_x : head.cmd.first_x - head.cmd.second_x;
	assign dya    = (head.cmd.second_y > head.cmd.first_y) ?
		head.cmd.second_y - head.cmd.first_y : head.cmd.first_y - head.cmd.second_y;
	assign steep0 = dya > dxa;
	assign dmaj0  = steep0 ? dya : dxa;
	assign dmin0  = steep0 ? dxa : dya;

	// Target pixel of the current step.
	always_comb begin
		tx = cx_q;
		ty = cy_q;
		case (op_q)
			OP_PIXEL: begin
				tx = cx_q;
				ty = cy_q;
			end
			OP_LINE: begin
				tx = steep_q ? ly_q : lx_q;
				ty = steep_q ? lx_q : ly_q;
			end
			OP_CIRCLE: begin
				case (oct_q)
					3'd0: begin tx = cx_q + ca_q[7:0]; ty = cy_q + cb_q[7:0]; end
					3'd1: begin tx = cx_q + cb_q[7:0]; ty = cy_q + ca_q[7:0]; end
					3'd2: begin tx = cx_q - ca_q[7:0]; ty = cy_q + cb_q[7:0]; end
					3'd3: begin tx = cx_q - cb_q[7:0]; ty = cy_q + ca_q[7:0]; end
					3'd4: begin tx = cx_q - ca_q[7:0]; ty = cy_q - cb_q[7:0]; end
					3'd5: begin tx = cx_q - cb_q[7:0]; ty = cy_q - ca_q[7:0]; end
					3'd6: begin tx = cx_q + ca_q[7:0]; ty = cy_q - cb_q[7:0]; end
					default: begin tx = cx_q + cb_q[7:0]; ty = cy_q - ca_q[7:0]; end
				endcase
			end
			default: begin
				tx = col_q[7:0];
				ty = row_q[7:0];
			end
		endcase
	end

	assign pix_vis = (9'(tx) < 9'(SCREEN_WIDTH)) && (9'(ty) < 9'(SCREEN_HEIGHT));
	assign row_ok  = (row_q < 9'(y2_q)) && (row_q < 9'(SCREEN_HEIGHT));
	assign col_ok  = (col_q < 9'(x2_q)) && (col_q < 9'(SCREEN_WIDTH));
	assign last    = (op_q == OP_PIXEL) || ((op_q == OP_LINE) && (cnt_q == '0));
	assign bmask   = 8'd1 << wbit_q;

	// Sequencer: next state and memory controls.
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		adv       = 1'b0;
		capture   = 1'b0;
		next_row  = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = pix_addr(tx, {3'b000, ty[7:3]});
		mem_waddr = waddr_q;
		mem_wdata = '0;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				if (clr_cnt_q == ADDR_W'(STORE_BYTES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					unique case (head.cmd.op)
						OP_CLEAR: state_d = ST_CLEAR;
						OP_READ: begin
							mem_re    = 1'b1;
							mem_raddr = ADDR_W'(head.cmd.byte_address);
							state_d   = ST_RDOUT;
						end
						default: state_d = ST_GEN;
					endcase
				end
			end
			ST_GEN: begin
				if (op_q == OP_INVERT) begin
					if (!row_ok) begin
						state_d = ST_IDLE;
					end else if (!col_ok) begin
						next_row = 1'b1;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = pix_addr(col_q[7:0], {3'b000, row_q[7:3]});
						capture   = 1'b1;
						state_d   = ST_WR;
					end
				end else if (op_q == OP_CIRCLE && oct_q == 3'd0 && ca_q < cb_q) begin
					state_d = ST_IDLE;
				end else if (pix_vis) begin
					mem_re  = 1'b1;
					capture = 1'b1;
					state_d = ST_WR;
				end else begin
					adv     = 1'b1;
					state_d = last ? ST_IDLE : ST_GEN;
				end
			end
			ST_WR: begin
				mem_we = 1'b1;
				if (op_q == OP_INVERT) mem_wdata = rdata_q ^ 8'hff;
				else if (pv_q)         mem_wdata = rdata_q | bmask;
				else                   mem_wdata = rdata_q & ~bmask;
				adv     = 1'b1;
				state_d = last ? ST_IDLE : ST_GEN;
			end
			ST_RDOUT: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Frame store: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem_q[mem_raddr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			clr_cnt_q    <= '0;
			read_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			read_valid_q <= (state_q == ST_RDOUT);
			if (state_q == ST_INIT || state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			else clr_cnt_q <= '0;
		end
	end

	// Command datapath: loaded on pop, stepped on each advance.
	always_ff @(posedge clk) begin
		if (state_q == ST_RDOUT) read_data_q <= rd_oob_q ? 8'h00 : rdata_q;
		if (capture) begin
			waddr_q <= mem_raddr;
			wbit_q  <= ty[2:0];
		end
		if (pop) begin
			op_q     <= head.cmd.op;
			pv_q     <= head.cmd.pixel_value;
			rd_oob_q <= !(14'(head.cmd.byte_address) < 14'(STORE_BYTES));
			cx_q     <= head.cmd.first_x;
			cy_q     <= head.cmd.first_y;
			ca_q     <= 9'(head.cmd.radius);
			cb_q     <= '0;
			cerr_q   <= 12'sd1 - 12'(head.cmd.radius);
			oct_q    <= '0;
			steep_q  <= steep0;
			lx_q     <= steep0 ? head.cmd.first_y : head.cmd.first_x;
			ly_q     <= steep0 ? head.cmd.first_x : head.cmd.first_y;
			mj_neg_q <= steep0 ? !(head.cmd.second_y > head.cmd.first_y)
				: !(head.cmd.second_x > head.cmd.first_x);
			mn_neg_q <= steep0 ? !(head.cmd.second_x > head.cmd.first_x)
				: !(head.cmd.second_y > head.cmd.first_y);
			dmaj_q   <= 9'(dmaj0);
			dmin_q   <= 9'(dmin0);
			e_q      <= $signed(12'({dmin0, 1'b0})) - $signed(12'(dmaj0));
			cnt_q    <= dmaj0;
			x1_q     <= head.cmd.first_x;
			x2_q     <= head.cmd.second_x;
			y2_q     <= head.cmd.second_y;
			row_q    <= 9'(head.cmd.first_y);
			col_q    <= 9'(head.cmd.first_x);
		end else if (next_row) begin
			row_q <= row_q + 9'd8;
			col_q <= 9'(x1_q);
		end else if (adv) begin
			case (op_q)
				OP_LINE: begin
					cnt_q <= cnt_q - 1'b1;
					lx_q  <= mj_neg_q ? lx_q - 1'b1 : lx_q + 1'b1;
					if (e_q >= 0) begin
						ly_q <= mn_neg_q ? ly_q - 1'b1 : ly_q + 1'b1;
						e_q  <= e_q - $signed(12'({dmaj_q, 1'b0})) + $signed(12'({dmin_q, 1'b0}));
					end else begin
						e_q  <= e_q + $signed(12'({dmin_q, 1'b0}));
					end
				end
				OP_CIRCLE: begin
					oct_q <= oct_q + 1'b1;
					if (oct_q == 3'd7) begin
						cb_q <= cb_q + 9'sd1;
						if (cerr_q < 0) begin
							cerr_q <= cerr_q + 12'(cb_q + 9'sd1) * 12'sd2 + 12'sd1;
						end else begin
							ca_q   <= ca_q - 9'sd1;
							cerr_q <= cerr_q + (12'(cb_q) - 12'(ca_q) + 12'sd3) * 12'sd2;
						end
					end
				end
				OP_INVERT: col_q <= col_q + 9'd1;
				default: ;
			endcase
		end
	end

	assign init_busy  = (state_q == ST_INIT);
	assign read_valid = read_valid_q;
	assign read_data  = read_data_q;

	a_valid_after_rdout: assert property (@(posedge clk) disable iff (!arst_n)
		read_valid_q |-> $past(state_q == ST_RDOUT)) else $error("stray read strobe");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we) else $error("store write while idle");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE) && head.valid) else $error("pop outside idle");
	a_wr_after_gen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> $past(state_q == ST_GEN)) else $error("write without read");

endmodule

>>> hdl/mono_framebuffer_draw_engine_unit.sv
// Monochrome 128x64 framebuffer with a small drawing engine.
// Commands enter on start while busy is low; kind selects clear, set or
// clear one pixel, Bresenham line, midpoint circle, page-stepped invert
// of a region, or a byte read. Kinds 6 and 7 are ignored.
// A two-item queue sits between the command decoder and the raster
// sequencer, so a new item is taken while the previous one still draws.
// Each drawn pixel is a read then a write of its store byte; pixels
// off the screen are skipped with no store access. Clear writes all
// 1024 store bytes, one byte per cycle. A read returns read_data
// with a one-cycle read_valid strobe; the byte passes through the
// store's read register and then the output register after the
// sequencer picks the read up from the queue.
// The receiver cannot stall: each result is shown for exactly one cycle.
// After reset the store is cleared by a pass over all 1024 bytes; busy
// stays high until it ends, and items are accepted only after that.
module mono_framebuffer_draw_engine_unit import mfde_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        kind,
	input  logic [7:0]        first_x,
	input  logic [7:0]        first_y,
	input  logic [7:0]        second_x,
	input  logic [7:0]        second_y,
	input  logic signed [7:0] radius,
	input  logic              pixel_value,
	input  logic [9:0]        byte_address,
	output logic              read_valid,
	output logic [7:0]        read_data
);

	q_head_t head;
	logic    pop;
	logic    init_busy;

	// Command decoder and queue.
	mfde_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .first_x(first_x), .first_y(first_y),
		.second_x(second_x), .second_y(second_y), .radius(radius),
		.pixel_value(pixel_value), .byte_address(byte_address),
		.init_busy(init_busy), .pop(pop), .head(head)
	);

	// Raster sequencer and frame store.
	mfde_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .pop(pop),
		.init_busy(init_busy), .read_valid(read_valid), .read_data(read_data)
	);

endmodule
